// ===== rtl/flash_write_combiner_core_defines.svh =====
// ----------------------------------------------------------------------------
// flash_write_combiner_core_defines
// Assertion macros used by the flash write combiner checker (fwc_checker).
// ----------------------------------------------------------------------------
`ifndef FLASH_WRITE_COMBINER_CORE_DEFINES_SVH
`define FLASH_WRITE_COMBINER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FWC_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FWC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fwc_pkg.sv =====
// ----------------------------------------------------------------------------
// fwc_pkg
// Types, constants and control bundles of the flash write combiner.
// ----------------------------------------------------------------------------
package fwc_pkg;

    localparam int BUFFER_BYTES_DEF = 128;
    localparam logic [7:0] PAD_BYTE = 8'hFF;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic        op;
        logic [31:0] byte_addr;
        logic [7:0]  byte_data;
        logic        call_last;
    } byte_item_t;

    typedef struct packed {
        logic [31:0] word_addr;
        logic [31:0] word_data;
        logic        padded;
        logic        burst_last;
    } word_item_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;     // hold the incoming byte for after the drain
        logic store_in;    // write the incoming byte into the buffer
        logic store_held;  // write the held byte into the buffer
        logic rd_start;    // read word 0
        logic rd_next;     // read the following word
        logic load_out;    // load the output register from the read word
        logic out_last;    // loaded word ends the burst
        logic clear_fill;  // buffer drained
    } fwc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic fill_zero;
        logic contig;
        logic fill_last_slot;
        logic last_word;
        logic out_free;
    } fwc_status_t;

endpackage

// ===== rtl/fwc_datapath.sv =====
// ----------------------------------------------------------------------------
// fwc_datapath
// Byte-lane buffer memory, run tracking, word readout and output register.
// ----------------------------------------------------------------------------
module fwc_datapath #(
    parameter int BUFFER_BYTES = fwc_pkg::BUFFER_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  fwc_pkg::byte_item_t byte_item,
    input  fwc_pkg::fwc_cmd_t   cmd,
    output fwc_pkg::fwc_status_t status,
    input  logic                word_ready,
    output logic                word_valid,
    output fwc_pkg::word_item_t word_item
);
    import fwc_pkg::*;

    localparam int WORDS  = BUFFER_BYTES / 4;
    localparam int IDX_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int FILL_W = $clog2(BUFFER_BYTES + 1);

    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [31:0]       run_start_reg, run_start_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              word_valid_reg, word_valid_next;
    word_item_t        word_item_reg, word_item_next;
    logic [31:0]       held_addr_reg;
    logic [7:0]        held_data_reg;

    logic              wr_en;
    logic [7:0]        wr_data;
    logic [31:0]       wr_addr;
    logic [1:0]        wr_lane;
    logic [IDX_W-1:0]  wr_idx;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [31:0]       rd_word;
    logic [FILL_W-1:0] fill_minus_one;
    logic [IDX_W-1:0]  last_idx;
    logic              pad_tail;
    logic [31:0]       packed_word;

    assign wr_en   = cmd.store_in | cmd.store_held;
    assign wr_data = cmd.store_held ? held_data_reg : byte_item.byte_data;
    assign wr_addr = cmd.store_held ? held_addr_reg : byte_item.byte_addr;
    assign wr_lane = fill_reg[1:0];
    assign wr_idx  = fill_reg[IDX_W+1:2];

    assign rd_en   = cmd.rd_start | cmd.rd_next;
    assign rd_addr = cmd.rd_start ? '0 : IDX_W'(rd_idx_reg + 1'b1);

    // Four byte-lane memories; lane = fill position modulo 4 (byte within the buffered word).
    for (genvar l = 0; l < 4; l++) begin : g_lane
        logic [7:0] mem [WORDS];
        logic [7:0] rd_lane_reg;

        always_ff @(posedge clk)
        begin
            if (wr_en && wr_lane == 2'(l))
            begin
                mem[wr_idx] <= wr_data;
            end
            if (rd_en)
            begin
                rd_lane_reg <= mem[rd_addr];
            end
        end

        assign rd_word[8*l +: 8] = rd_lane_reg;
    end

    assign fill_minus_one = fill_reg - 1'b1;
    assign last_idx       = fill_minus_one[IDX_W+1:2];

    assign status.fill_zero      = (fill_reg == '0);
    assign status.contig         = (byte_item.byte_addr == run_start_reg + 32'(fill_reg));
    assign status.fill_last_slot = (fill_reg == FILL_W'(BUFFER_BYTES - 1));
    assign status.last_word      = (rd_idx_reg == last_idx);
    assign status.out_free       = ~word_valid_reg | word_ready;

    // Partial tail: lanes at or past the fill point get the pad byte.
    assign pad_tail = status.last_word && (fill_reg[1:0] != 2'd0);

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (pad_tail && 2'(i) >= fill_reg[1:0])
            begin
                packed_word[8*i +: 8] = PAD_BYTE;
            end
            else
            begin
                packed_word[8*i +: 8] = rd_word[8*i +: 8];
            end
        end
    end

    always_comb
    begin
        fill_next       = fill_reg;
        run_start_next  = run_start_reg;
        rd_idx_next     = rd_idx_reg;
        word_valid_next = word_valid_reg;
        word_item_next  = word_item_reg;

        if (cmd.clear_fill)
        begin
            fill_next = '0;
        end
        else if (wr_en)
        begin
            fill_next = fill_reg + 1'b1;
            if (fill_reg == '0)
            begin
                run_start_next = wr_addr;
            end
        end

        if (cmd.rd_start)
        begin
            rd_idx_next = '0;
        end
        else if (cmd.rd_next)
        begin
            rd_idx_next = rd_addr;
        end

        if (cmd.load_out)
        begin
            word_valid_next           = 1'b1;
            word_item_next.word_addr  = run_start_reg
                                      + {{(30-IDX_W){1'b0}}, rd_idx_reg, 2'b00};
            word_item_next.word_data  = packed_word;
            word_item_next.padded     = pad_tail;
            word_item_next.burst_last = cmd.out_last;
        end
        else if (word_ready)
        begin
            word_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            run_start_reg  <= '0;
            rd_idx_reg     <= '0;
            word_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg       <= fill_next;
            run_start_reg  <= run_start_next;
            rd_idx_reg     <= rd_idx_next;
            word_valid_reg <= word_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_item_reg <= word_item_next;
        if (cmd.capture)
        begin
            held_addr_reg <= byte_item.byte_addr;
            held_data_reg <= byte_item.byte_data;
        end
    end

    assign word_valid = word_valid_reg;
    assign word_item  = word_item_reg;

endmodule

// ===== rtl/fwc_ctrl.sv =====
// ----------------------------------------------------------------------------
// fwc_ctrl
// Sequencer of the flash write combiner: byte intake, word drain, held byte.
// ----------------------------------------------------------------------------
module fwc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    input  logic                 op,
    output logic                 byte_ready,
    output fwc_pkg::fwc_cmd_t    cmd,
    input  fwc_pkg::fwc_status_t status
);
    import fwc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_LOAD,
        S_STORE
    } state_t;

    state_t state_reg, state_next;
    logic   held_reg, held_next;
    logic   accept;

    assign byte_ready = (state_reg == S_IDLE);
    assign accept     = byte_valid & byte_ready;

    always_comb
    begin
        state_next = state_reg;
        held_next  = held_reg;
        cmd        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (op == OP_FLUSH)
                    begin
                        if (!status.fill_zero)
                        begin
                            state_next = S_START;
                        end
                    end
                    else if (!status.fill_zero && !status.contig)
                    begin
                        // Break in the run: drain first, store the byte after.
                        cmd.capture = 1'b1;
                        held_next   = 1'b1;
                        state_next  = S_START;
                    end
                    else
                    begin
                        cmd.store_in = 1'b1;
                        if (status.fill_last_slot)
                        begin
                            state_next = S_START;
                        end
                    end
                end
            end

            S_START:
            begin
                cmd.rd_start = 1'b1;
                state_next   = S_LOAD;
            end

            S_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_last = status.last_word;
                    if (status.last_word)
                    begin
                        cmd.clear_fill = 1'b1;
                        state_next     = held_reg ? S_STORE : S_IDLE;
                    end
                    else
                    begin
                        cmd.rd_next = 1'b1;
                    end
                end
            end

            S_STORE:
            begin
                cmd.store_held = 1'b1;
                held_next      = 1'b0;
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
                held_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            held_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
        end
    end

endmodule

// ===== rtl/flash_write_combiner_core.sv =====
// ----------------------------------------------------------------------------
// flash_write_combiner_core
// Packs a stream of byte writes into 32-bit flash word writes.
// ----------------------------------------------------------------------------
// Input channel byte_valid/byte_ready/byte_item carries a byte write (op write)
// or a flush (op flush). Output channel word_valid/word_ready/word_item carries
// flash words; burst_last marks the last word caused by one input transfer.
// A byte that continues the held run is stored as it is accepted and the next
// byte may follow in the next cycle. A flush of a non-empty buffer, a break in
// the run, or the buffer reaching BUFFER_BYTES (a multiple of 4) starts a drain:
// a start state issues the buffer memory read, then one word per cycle while
// word_ready is high. A break in the run then stores the new byte in a final
// store state. byte_ready is low for the whole drain; the last word may still
// wait in the output register while the next byte is taken.
// A stalled receiver holds word_item and pauses the drain on the word in hand.
// Reset empties the buffer and drops any pending word; the buffer memory
// itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module flash_write_combiner_core #(
    parameter int BUFFER_BYTES = fwc_pkg::BUFFER_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_ready,
    input  fwc_pkg::byte_item_t byte_item,
    output logic                word_valid,
    input  logic                word_ready,
    output fwc_pkg::word_item_t word_item
);
    import fwc_pkg::*;

    fwc_cmd_t    cmd;
    fwc_status_t status;

    fwc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .op         (byte_item.op),
        .byte_ready (byte_ready),
        .cmd        (cmd),
        .status     (status)
    );

    fwc_datapath #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_item  (byte_item),
        .cmd        (cmd),
        .status     (status),
        .word_ready (word_ready),
        .word_valid (word_valid),
        .word_item  (word_item)
    );

endmodule

// ===== rtl/fwc_checker.sv =====
// ----------------------------------------------------------------------------
// fwc_checker
// Port-level checks of the flash write combiner, bound to the top level.
// ----------------------------------------------------------------------------
`include "flash_write_combiner_core_defines.svh"

module fwc_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                byte_valid,
    input logic                byte_ready,
    input fwc_pkg::byte_item_t byte_item,
    input logic                word_valid,
    input logic                word_ready,
    input fwc_pkg::word_item_t word_item
);
    import fwc_pkg::*;

    logic        in_burst_reg, in_burst_next;
    logic [31:0] exp_addr_reg, exp_addr_next;
    logic        word_xfer;

    assign word_xfer = word_valid & word_ready;

    // Track the address the next word of an open burst must carry.
    always_comb
    begin
        in_burst_next = in_burst_reg;
        exp_addr_next = exp_addr_reg;
        if (word_xfer)
        begin
            in_burst_next = ~word_item.burst_last;
            exp_addr_next = word_item.word_addr + 32'd4;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_burst_reg <= 1'b0;
            exp_addr_reg <= '0;
        end
        else
        begin
            in_burst_reg <= in_burst_next;
            exp_addr_reg <= exp_addr_next;
        end
    end

    `FWC_ASSERT_NEXT(a_word_hold, word_valid && !word_ready, word_valid && $stable(word_item), "word transfer changed while stalled")
    `FWC_ASSERT_NOW(a_pad_ends_burst, word_valid && word_item.padded, word_item.burst_last && (word_item.word_data[31:24] == PAD_BYTE), "padded word not last or top byte not padded")
    `FWC_ASSERT_NOW(a_burst_addr_step, word_valid && in_burst_reg, word_item.word_addr == exp_addr_reg, "burst word address not contiguous")
    `FWC_ASSERT_NOW(a_ready_drop_on_xfer, $fell(byte_ready), $past(byte_valid), "byte_ready fell without a byte transfer")

endmodule

bind flash_write_combiner_core fwc_checker u_fwc_checker (.*);

// ===== tb/flash_write_combiner_core_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flash_write_combiner_core_checker
// Watches both channels of the write combiner. Every accepted byte or flush
// is run through a software copy of the byte buffer to build the flash words
// it should produce; every accepted word is compared against the oldest one.
// ----------------------------------------------------------------------------
module flash_write_combiner_core_checker #(
    parameter int BUFFER_BYTES = fwc_pkg::BUFFER_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    input  logic                byte_ready,
    input  fwc_pkg::byte_item_t byte_item,
    input  logic                word_valid,
    input  logic                word_ready,
    input  fwc_pkg::word_item_t word_item,
    output int unsigned         fail_count,
    output int unsigned         words_pending
);
    import fwc_pkg::*;

    logic [7:0]  held_bytes [BUFFER_BYTES];
    int unsigned held_count;
    logic [31:0] run_base;
    word_item_t  flash_word_q [$];

    function automatic void queue_flash_word(logic [31:0] addr, logic [31:0] data,
                                             logic pad);
        word_item_t w;
        w.word_addr  = addr;
        w.word_data  = data;
        w.padded     = pad;
        w.burst_last = 1'b0;
        flash_word_q.push_back(w);
    endfunction

    // Emit every whole word held, then move the leftover bytes to the front.
    function automatic void drain_whole_words();
        int unsigned whole;
        int unsigned k;
        whole = held_count & ~32'd3;
        if (whole == 0)
            return;
        for (k = 0; k < whole; k += 4)
            queue_flash_word(run_base + 32'(k),
                             {held_bytes[k + 3], held_bytes[k + 2],
                              held_bytes[k + 1], held_bytes[k]}, 1'b0);
        held_count -= whole;
        run_base += 32'(whole);
        for (k = 0; k < held_count; k++)
            held_bytes[k] = held_bytes[k + whole];
    endfunction

    function automatic void drain_all();
        logic [31:0] tail;
        int unsigned k;
        drain_whole_words();
        if (held_count == 0)
            return;
        for (k = 0; k < 4; k++)
            tail[8*k +: 8] = (k < held_count) ? held_bytes[k] : PAD_BYTE;
        queue_flash_word(run_base, tail, 1'b1);
        run_base += 32'd4;
        held_count = 0;
    endfunction

    function automatic void predict_flash_words(byte_item_t b);
        int unsigned queued_before;
        queued_before = flash_word_q.size();
        if (b.op == OP_FLUSH)
        begin
            drain_all();
        end
        else
        begin
            // a byte that breaks the run pushes the whole run out first
            if (held_count > 0 && b.byte_addr != run_base + 32'(held_count))
                drain_all();
            if (held_count == 0)
                run_base = b.byte_addr;
            held_bytes[held_count] = b.byte_data;
            held_count++;
            if (held_count >= BUFFER_BYTES)
                drain_whole_words();
        end
        if (flash_word_q.size() > queued_before)
            flash_word_q[flash_word_q.size() - 1].burst_last = 1'b1;
    endfunction

    task automatic check_flash_word(word_item_t got);
        word_item_t want;
        if (flash_word_q.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: unexpected word addr=%h data=%h padded=%0b last=%0b",
                         $realtime, got.word_addr, got.word_data, got.padded,
                         got.burst_last);
            return;
        end
        want = flash_word_q.pop_front();
        if (got.word_addr !== want.word_addr || got.word_data !== want.word_data ||
            got.padded !== want.padded || got.burst_last !== want.burst_last)
        begin
            fail_count++;
            if (fail_count <= 10)
            begin
                $display("%0t: word mismatch: expected addr=%h data=%h padded=%0b last=%0b",
                         $realtime, want.word_addr, want.word_data, want.padded,
                         want.burst_last);
                $display("%0t: word mismatch: got addr=%h data=%h padded=%0b last=%0b",
                         $realtime, got.word_addr, got.word_data, got.padded,
                         got.burst_last);
            end
        end
    endtask

    // Check the word side first so a stray word cannot match a fresh prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count = 0;
            run_base = '0;
            flash_word_q.delete();
            fail_count = 0;
            words_pending = 0;
        end
        else
        begin
            if (word_valid && word_ready)
                check_flash_word(word_item);
            if (byte_valid && byte_ready)
                predict_flash_words(byte_item);
            words_pending = flash_word_q.size();
        end
    end

endmodule

// ===== tb/flash_write_combiner_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flash_write_combiner_core_tb
// Drives byte writes and flushes into the write combiner: a directed pass over
// address wrap, broken runs and empty flushes, then random runs of contiguous
// bytes with flushes and noise. The word receiver stalls at random and once
// for a long stretch so the buffer fills and the input backs up.
// ----------------------------------------------------------------------------
module flash_write_combiner_core_tb;
    import fwc_pkg::*;

    localparam int BUFFER_BYTES  = BUFFER_BYTES_DEF;
    localparam int ITEM_TARGET   = 480;
    localparam int QUIET_ITEMS   = 60;
    localparam int LONG_HOLD     = 500;
    localparam int HOLD_RUN      = 200;
    localparam int DRAIN_CYCLES  = 60;
    localparam int CYCLE_LIMIT   = 1_000_000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_ready;
    byte_item_t  byte_item = '0;
    logic        word_valid;
    logic        word_ready = 1'b0;
    word_item_t  word_item;

    int unsigned fail_count;
    int unsigned words_pending;
    int unsigned items_sent = 0;
    int unsigned cycle_count = 0;
    bit          quiet = 1'b0;
    bit          hold_go = 1'b0;
    bit          hold_done = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    flash_write_combiner_core #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .word_valid (word_valid),
        .word_ready (word_ready),
        .word_item  (word_item)
    );

    flash_write_combiner_core_checker #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_ready    (byte_ready),
        .byte_item     (byte_item),
        .word_valid    (word_valid),
        .word_ready    (word_ready),
        .word_item     (word_item),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Hold the item until it is taken; now and then (not when quiet) idle for a random stretch beforehand.
    task automatic send_byte_item(logic op, logic [31:0] addr, logic [7:0] data,
                                  logic call_last);
        byte_item_t it;
        it.op = op;
        it.byte_addr = addr;
        it.byte_data = data;
        it.call_last = call_last;
        if (!quiet && $urandom_range(0, 9) == 0)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item <= it;
        do @(posedge clk); while (!byte_ready);
        items_sent++;
    endtask

    task automatic send_run(logic [31:0] start, int unsigned len);
        int unsigned i;
        for (i = 0; i < len; i++)
            send_byte_item(OP_WRITE, start + 32'(i), 8'($urandom),
                           (i == len - 1) || ($urandom_range(0, 7) == 0));
    endtask

    // Bias start addresses toward both ends of the space so runs wrap.
    function automatic logic [31:0] pick_addr();
        case ($urandom_range(0, 3))
            0: return 32'hFFFF_FFFF - 32'($urandom_range(0, 40));
            1: return 32'($urandom_range(0, 300));
            default: return $urandom;
        endcase
    endfunction

    initial
    begin : word_sink
        forever
        begin
            if (hold_go && !hold_done)
            begin
                word_ready <= 1'b0;
                hold_done = 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                word_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else
            begin
                word_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin : byte_source
        int unsigned pick;
        int unsigned len;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // flush with nothing held
        send_byte_item(OP_FLUSH, 32'h0000_0000, 8'h00, 1'b0);
        // run that wraps past the top of the address space, then a padded tail
        send_byte_item(OP_WRITE, 32'hFFFF_FFFE, 8'h00, 1'b0);
        send_byte_item(OP_WRITE, 32'hFFFF_FFFF, 8'hFF, 1'b0);
        send_byte_item(OP_WRITE, 32'h0000_0000, 8'hA5, 1'b1);
        send_byte_item(OP_FLUSH, 32'hFFFF_FFFF, 8'hFF, 1'b1);
        // five bytes, then a jump: whole word plus padded tail before the store
        send_byte_item(OP_WRITE, 32'h0000_1000, 8'h11, 1'b0);
        send_byte_item(OP_WRITE, 32'h0000_1001, 8'h22, 1'b0);
        send_byte_item(OP_WRITE, 32'h0000_1002, 8'h33, 1'b0);
        send_byte_item(OP_WRITE, 32'h0000_1003, 8'h44, 1'b0);
        send_byte_item(OP_WRITE, 32'h0000_1004, 8'h55, 1'b1);
        send_byte_item(OP_WRITE, 32'h0000_2000, 8'h66, 1'b0);
        send_byte_item(OP_WRITE, 32'h0000_2001, 8'h01, 1'b0);
        send_byte_item(OP_WRITE, 32'h0000_2002, 8'h80, 1'b0);
        send_byte_item(OP_WRITE, 32'h0000_2003, 8'hFE, 1'b1);
        // exactly one whole word: no padding
        send_byte_item(OP_FLUSH, 32'h8000_0000, 8'h80, 1'b0);
        send_byte_item(OP_FLUSH, 32'h7FFF_FFFF, 8'h7F, 1'b1);
        // repeated and backward addresses break the run
        send_byte_item(OP_WRITE, 32'h0000_3000, 8'h77, 1'b0);
        send_byte_item(OP_WRITE, 32'h0000_3000, 8'h88, 1'b0);
        send_byte_item(OP_WRITE, 32'h0000_2FFF, 8'h99, 1'b1);
        send_byte_item(OP_FLUSH, 32'h5555_5555, 8'hAA, 1'b0);

        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent + QUIET_ITEMS >= ITEM_TARGET)
                quiet = 1'b1;
            if (!hold_go && items_sent >= 150)
            begin
                // stall the receiver and keep offering one long run
                hold_go = 1'b1;
                send_run(pick_addr(), HOLD_RUN);
                send_byte_item(OP_FLUSH, $urandom, 8'($urandom), 1'($urandom));
            end
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                  : $urandom_range(1, 24);
                // keep the total close to the target
                if (items_sent < ITEM_TARGET && len > ITEM_TARGET - items_sent)
                    len = ITEM_TARGET - items_sent;
                send_run(pick_addr(), len);
                if ($urandom_range(0, 1) == 0)
                    send_byte_item(OP_FLUSH, $urandom, 8'($urandom), 1'($urandom));
            end
            else if (pick < 85)
                send_byte_item(OP_WRITE, $urandom, 8'($urandom), 1'($urandom));
            else
                send_byte_item(OP_FLUSH, $urandom, 8'($urandom), 1'($urandom));
        end
        send_byte_item(OP_FLUSH, $urandom, 8'($urandom), 1'b1);
        byte_valid <= 1'b0;

        // let the checker take the last transfer before looking at its queue
        @(negedge clk);
        while (words_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && words_pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== flash_write_combiner_core.f =====
+incdir+rtl
rtl/fwc_pkg.sv
rtl/fwc_datapath.sv
rtl/fwc_ctrl.sv
rtl/flash_write_combiner_core.sv
rtl/fwc_checker.sv
tb/flash_write_combiner_core_checker.sv
tb/flash_write_combiner_core_tb.sv
